/* hw/rtl/hlrd_pkg.sv */
// ----------------------------------------------------------------------------
// hlrd_pkg
// Shared types and constants of the hash leaf record deframer.
// ----------------------------------------------------------------------------
package hlrd_pkg;

  // default size of the page number field in the header
  localparam int unsigned PAGE_BYTES_DEF = 8;

  // fixed header layout, byte offsets from the first header byte
  localparam int unsigned HDR_NL_OFS   = 0;
  localparam int unsigned HDR_TL_OFS   = 2;
  localparam int unsigned HDR_DEL_OFS  = 4;
  localparam int unsigned HDR_PAGE_OFS = 5;

  // reset values of the type code registers
  localparam logic [7:0] PRESENT_CODE_RST = 8'd0;
  localparam logic [7:0] DELETED_CODE_RST = 8'd1;
  localparam logic [7:0] END_CODE_RST     = 8'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRESENT = 2'd0,
    CFG_DELETED = 2'd1,
    CFG_END     = 2'd2
  } cfg_idx_e;

  // parser phase
  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_HDR  = 3'd1,
    PH_NAME = 3'd2,
    PH_TSTR = 3'd3,
    PH_EOT  = 3'd4,
    PH_BADT = 3'd5,
    PH_BADH = 3'd6
  } phase_e;

  // classification of one byte
  typedef enum logic [2:0] {
    K_TYPE = 3'd0,
    K_HDR  = 3'd1,
    K_NAME = 3'd2,
    K_TSTR = 3'd3,
    K_EOT  = 3'd4,
    K_BADT = 3'd5,
    K_BADH = 3'd6,
    K_IGN  = 3'd7
  } kind_e;

  // type codes from the configuration registers
  typedef struct packed {
    logic [7:0] present_code;
    logic [7:0] deleted_code;
    logic [7:0] end_code;
  } codes_t;

  // per-byte parse result
  typedef struct packed {
    kind_e        kind;
    logic [15:0]  sidx;
    logic         del;
    logic         last;
    logic         hv;
    logic [15:0]  name_len;
    logic [15:0]  type_len;
    logic [63:0]  page;
  } result_t;

endpackage

/* hw/rtl/hlrd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hlrd_cfg_regs
// Type code registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module hlrd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [1:0]        index_i,
  input  logic [7:0]        data_i,
  output hlrd_pkg::codes_t  codes_o
);

  hlrd_pkg::codes_t codes_q, codes_d;

  // register write decode, writes beyond the list are dropped
  always_comb begin
    codes_d = codes_q;
    if (we_i) begin
      unique case (hlrd_pkg::cfg_idx_e'(index_i))
        hlrd_pkg::CFG_PRESENT: codes_d.present_code = data_i;
        hlrd_pkg::CFG_DELETED: codes_d.deleted_code = data_i;
        hlrd_pkg::CFG_END:     codes_d.end_code     = data_i;
        default:               codes_d = codes_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.present_code <= hlrd_pkg::PRESENT_CODE_RST;
      codes_q.deleted_code <= hlrd_pkg::DELETED_CODE_RST;
      codes_q.end_code     <= hlrd_pkg::END_CODE_RST;
    end else begin
      codes_q <= codes_d;
    end
  end

  assign codes_o = codes_q;

endmodule

/* hw/rtl/hlrd_parser.sv */
// ----------------------------------------------------------------------------
// hlrd_parser
// Record parse state and per-byte classification, one byte per advance.
// ----------------------------------------------------------------------------
module hlrd_parser #(
  parameter int unsigned PAGE_BYTES = hlrd_pkg::PAGE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [7:0]          byte_i,
  input  hlrd_pkg::codes_t    codes_i,
  output hlrd_pkg::result_t   res_o
);

  localparam int unsigned HDR_BYTES = hlrd_pkg::HDR_PAGE_OFS + PAGE_BYTES;
  localparam int unsigned PAGE_W    = 8 * PAGE_BYTES;

  hlrd_pkg::phase_e    phase_q, phase_d;
  logic [15:0]         count_q, count_d;
  logic [15:0]         nl_q, nl_d;
  logic [15:0]         tl_q, tl_d;
  logic                del_q, del_d;
  logic [PAGE_W-1:0]   page_q, page_d;

  logic [15:0]         nl_m, tl_m;
  logic                del_m;
  logic [PAGE_W-1:0]   page_m;
  logic                hit_present, hit_deleted, hit_end;
  logic                hdr_last, hdr_bad, name_done, tstr_done;
  logic [15:0]         count_inc;

  // type byte match
  assign hit_present = (byte_i == codes_i.present_code);
  assign hit_deleted = (byte_i == codes_i.deleted_code);
  assign hit_end     = (byte_i == codes_i.end_code);

  // header fields with the current header byte merged in
  always_comb begin
    nl_m   = nl_q;
    tl_m   = tl_q;
    del_m  = del_q;
    page_m = page_q;
    if (phase_q == hlrd_pkg::PH_HDR) begin
      if (count_q == 16'(hlrd_pkg::HDR_NL_OFS))     nl_m[7:0]  = byte_i;
      if (count_q == 16'(hlrd_pkg::HDR_NL_OFS + 1)) nl_m[15:8] = byte_i;
      if (count_q == 16'(hlrd_pkg::HDR_TL_OFS))     tl_m[7:0]  = byte_i;
      if (count_q == 16'(hlrd_pkg::HDR_TL_OFS + 1)) tl_m[15:8] = byte_i;
      if (count_q == 16'(hlrd_pkg::HDR_DEL_OFS))    del_m      = (byte_i != 8'd0);
      for (int unsigned i = 0; i < PAGE_BYTES; i++) begin
        if (count_q == 16'(hlrd_pkg::HDR_PAGE_OFS + i)) page_m[8*i +: 8] = byte_i;
      end
    end
  end

  // end-of-field checks
  assign count_inc = count_q + 16'd1;
  assign hdr_last  = (count_q >= 16'(HDR_BYTES - 1));
  assign hdr_bad   = (nl_m == 16'd0) || (tl_m == 16'd0) || (page_m == '0);
  assign name_done = ({1'b0, count_q} + 17'd1) >= {1'b0, nl_q};
  assign tstr_done = ({1'b0, count_q} + 17'd1) >= {1'b0, tl_q};

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    nl_d    = nl_m;
    tl_d    = tl_m;
    del_d   = del_m;
    page_d  = page_m;
    unique case (phase_q)
      hlrd_pkg::PH_TYPE: begin
        count_d = '0;
        nl_d    = '0;
        tl_d    = '0;
        page_d  = '0;
        del_d   = !hit_present && hit_deleted;
        priority if (hit_present || hit_deleted) phase_d = hlrd_pkg::PH_HDR;
        else if (hit_end)                          phase_d = hlrd_pkg::PH_EOT;
        else                                       phase_d = hlrd_pkg::PH_BADT;
      end
      hlrd_pkg::PH_HDR: begin
        if (hdr_last && hdr_bad) begin
          phase_d = hlrd_pkg::PH_BADH;
          count_d = '0;
          nl_d    = '0;
          tl_d    = '0;
          del_d   = 1'b0;
          page_d  = '0;
        end else if (hdr_last) begin
          phase_d = hlrd_pkg::PH_NAME;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      hlrd_pkg::PH_NAME: begin
        if (name_done) begin
          phase_d = hlrd_pkg::PH_TSTR;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      hlrd_pkg::PH_TSTR: begin
        if (tstr_done) begin
          phase_d = hlrd_pkg::PH_TYPE;
          count_d = '0;
          nl_d    = '0;
          tl_d    = '0;
          del_d   = 1'b0;
          page_d  = '0;
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // per-byte result
  always_comb begin
    res_o      = '0;
    res_o.kind = hlrd_pkg::K_IGN;
    unique case (phase_q)
      hlrd_pkg::PH_TYPE: begin
        priority if (hit_present) begin
          res_o.kind = hlrd_pkg::K_TYPE;
        end else if (hit_deleted) begin
          res_o.kind = hlrd_pkg::K_TYPE;
          res_o.del  = 1'b1;
        end else if (hit_end) begin
          res_o.kind = hlrd_pkg::K_EOT;
        end else begin
          res_o.kind = hlrd_pkg::K_BADT;
        end
      end
      hlrd_pkg::PH_HDR: begin
        if (hdr_last && hdr_bad) begin
          res_o.kind = hlrd_pkg::K_BADH;
        end else begin
          res_o.kind = hlrd_pkg::K_HDR;
          res_o.del  = del_m;
          if (hdr_last) begin
            res_o.hv       = 1'b1;
            res_o.name_len = nl_m;
            res_o.type_len = tl_m;
            res_o.page     = 64'(page_m);
          end
        end
      end
      hlrd_pkg::PH_NAME, hlrd_pkg::PH_TSTR: begin
        res_o.kind     = (phase_q == hlrd_pkg::PH_NAME) ? hlrd_pkg::K_NAME
                                                        : hlrd_pkg::K_TSTR;
        res_o.hv       = 1'b1;
        res_o.del      = del_q;
        res_o.sidx     = count_q;
        res_o.last     = (phase_q == hlrd_pkg::PH_TSTR) && tstr_done;
        res_o.name_len = nl_q;
        res_o.type_len = tl_q;
        res_o.page     = 64'(page_q);
      end
      default: begin
        res_o.kind = hlrd_pkg::K_IGN;
      end
    endcase
  end

  // parse state, advanced once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hlrd_pkg::PH_TYPE;
      count_q <= '0;
      nl_q    <= '0;
      tl_q    <= '0;
      del_q   <= 1'b0;
      page_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      nl_q    <= nl_d;
      tl_q    <= tl_d;
      del_q   <= del_d;
      page_q  <= page_d;
    end
  end

  // end-of-table and corrupt states hold until reset
  a_held_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hlrd_pkg::PH_EOT || phase_q == hlrd_pkg::PH_BADT ||
     phase_q == hlrd_pkg::PH_BADH) |=> $stable(phase_q))
    else $error("held phase left before reset");

  // a reported header never carries a zero length or page
  a_good_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.hv |-> (res_o.name_len != 16'd0 && res_o.type_len != 16'd0 &&
                  res_o.page != 64'd0))
    else $error("header reported valid with zero field");

  // record end only on a type-string byte
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.last |-> (res_o.kind == hlrd_pkg::K_TSTR && res_o.hv))
    else $error("record end on a non type-string byte");

  // every record starts from a cleared counter
  a_type_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hlrd_pkg::PH_TYPE) |-> (count_q == 16'd0 && nl_q == 16'd0))
    else $error("header state not cleared at record start");

endmodule

/* hw/rtl/hash_leaf_record_deframer_unit.sv */
// ----------------------------------------------------------------------------
// hash_leaf_record_deframer_unit
// Byte-serial parser of hash leaf records, one classified beat per byte.
// ----------------------------------------------------------------------------
// Usage:
//   - input channel: in_valid_i / in_stall_o carry one raw stream byte a beat
//   - output channel: out_valid_o / out_stall_i carry one result beat for
//     every input byte: the byte, its kind, string index, deleted and
//     record-end flags, and the header fields once the header is parsed
//   - configuration channel: cfg_valid_i / cfg_ready_o writes the present,
//     deleted and end type codes (index 0, 1, 2); write only while idle
//   - path: a taken byte passes the input register, then the result
//     register, before its result beat is offered
//   - throughput: one byte per cycle while the receiver does not stall, set
//     by the single parse step between the input register and the result register
//   - reset: parser expects a type byte, codes return to 0, 1 and 2
//   - when the receiver stalls, the result register holds; one more byte is
//     taken into the input register, after which in_stall_o rises
//   - end-of-table and corrupt records hold the parser until reset; later
//     bytes come out as ignored
// ----------------------------------------------------------------------------
module hash_leaf_record_deframer_unit #(
  parameter int unsigned PAGE_BYTES = hlrd_pkg::PAGE_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input channel
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   in_byte_i,
  // output channel
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic [2:0]   byte_kind_o,
  output logic [15:0]  string_index_o,
  output logic         deleted_o,
  output logic         record_last_o,
  output logic         header_valid_o,
  output logic [15:0]  name_length_o,
  output logic [15:0]  type_length_o,
  output logic [63:0]  first_page_o,
  // configuration channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  hlrd_pkg::codes_t   codes;
  hlrd_pkg::result_t  res, res_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_free, adv, in_take;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  hlrd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .codes_o (codes)
  );

  // pipeline handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
  end

  // parse step
  hlrd_parser #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .codes_i (codes),
    .res_o   (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= in_byte_q;
      res_q      <= res;
    end
  end

  // output beat
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_kind_o    = res_q.kind;
  assign string_index_o = res_q.sidx;
  assign deleted_o      = res_q.del;
  assign record_last_o  = res_q.last;
  assign header_valid_o = res_q.hv;
  assign name_length_o  = res_q.name_len;
  assign type_length_o  = res_q.type_len;
  assign first_page_o   = res_q.page;

endmodule
